// ===== sv/npsmc_pkg.sv =====
// Package for the tube panel scan and menu controller.
// Request and config types, register indexes, reset values, press pattern.
// No dependencies.
package npsmc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INACTIVITY_TICKS = 3'd0,
        CFG_BLINK_PERIOD     = 3'd1,
        CFG_BLINK_DARK       = 3'd2,
        CFG_COLON_ON_LIMIT   = 3'd3,
        CFG_SECOND_WRAP      = 3'd4
    } cfg_index_t;

    typedef enum logic {
        REQ_BUTTON = 1'b0,
        REQ_SCAN   = 1'b1
    } req_type_t;

    localparam logic [7:0]  PRESS_PATTERN      = 8'b1111_0000;
    localparam logic [3:0]  DIGIT_LIMIT        = 4'd10;

    localparam logic [15:0] RST_INACTIVITY     = 16'd10000;
    localparam logic [8:0]  RST_BLINK_PERIOD   = 9'd340;
    localparam logic [8:0]  RST_BLINK_DARK     = 9'd50;
    localparam logic [9:0]  RST_COLON_ON_LIMIT = 10'd499;
    localparam logic [9:0]  RST_SECOND_WRAP    = 10'd999;

    // One captured request
    typedef struct packed {
        req_type_t  kind;
        logic       hour_level;
        logic       menu_level;
        logic       minute_level;
        logic [3:0] digit_zero;
        logic [3:0] digit_one;
        logic [3:0] digit_two;
        logic [3:0] digit_three;
        logic [7:0] blink_mask;
    } req_t;

    // Configuration register file
    typedef struct packed {
        logic [15:0] inactivity_ticks;
        logic [8:0]  blink_period;
        logic [8:0]  blink_dark;
        logic [9:0]  colon_on_limit;
        logic [9:0]  second_wrap;
    } cfg_t;

endpackage

// ===== sv/nixie_panel_scan_and_menu_ctrl_top.sv =====
// Each request passes through the input register, then the result register.
// Throughput: one request per cycle sustained unless the result side stalls; set by the
// single update pass between the input register and the result register.
// Reset: rst_n asynchronous, active low; config registers load their defaults,
// histories, menu state, counters and scan position clear to zero. Depends on npsmc_pkg.
module nixie_panel_scan_and_menu_ctrl_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic                             req_type,
    input  logic                             hour_button_level,
    input  logic                             menu_button_level,
    input  logic                             minute_button_level,
    input  logic [3:0]                       digit_zero,
    input  logic [3:0]                       digit_one,
    input  logic [3:0]                       digit_two,
    input  logic [3:0]                       digit_three,
    input  logic [7:0]                       blink_mask,
    // result channel
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [3:0]                       anode_lines,
    output logic [9:0]                       cathode_lines,
    output logic                             colon_lamp,
    output logic                             menu_active,
    output logic                             hour_step,
    output logic                             minute_step,
    output logic [15:0]                      inactivity_left,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [npsmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [npsmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import npsmc_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline handshake: input reg (s1) feeds the result reg (out).
    // The result reg loads whenever it is empty or being taken, so a new
    // request enters every cycle unless the result side stalls.
    // ------------------------------------------------------------------
    logic  s1_valid_reg;
    req_t  s1_reg;
    logic  out_load;
    logic  s1_load;

    assign out_load  = !rsp_valid || !rsp_stall;
    assign req_stall = s1_valid_reg && !out_load;
    assign s1_load   = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inactivity_ticks <= RST_INACTIVITY;
            cfg_reg.blink_period     <= RST_BLINK_PERIOD;
            cfg_reg.blink_dark       <= RST_BLINK_DARK;
            cfg_reg.colon_on_limit   <= RST_COLON_ON_LIMIT;
            cfg_reg.second_wrap      <= RST_SECOND_WRAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INACTIVITY_TICKS: cfg_reg.inactivity_ticks <= cfg_data;
                CFG_BLINK_PERIOD:     cfg_reg.blink_period     <= cfg_data[8:0];
                CFG_BLINK_DARK:       cfg_reg.blink_dark       <= cfg_data[8:0];
                CFG_COLON_ON_LIMIT:   cfg_reg.colon_on_limit   <= cfg_data[9:0];
                CFG_SECOND_WRAP:      cfg_reg.second_wrap      <= cfg_data[9:0];
                default: ;  // writes outside the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg.kind         <= req_type_t'(req_type);
            s1_reg.hour_level   <= hour_button_level;
            s1_reg.menu_level   <= menu_button_level;
            s1_reg.minute_level <= minute_button_level;
            s1_reg.digit_zero   <= digit_zero;
            s1_reg.digit_one    <= digit_one;
            s1_reg.digit_two    <= digit_two;
            s1_reg.digit_three  <= digit_three;
            s1_reg.blink_mask   <= blink_mask;
        end
    end

    // ------------------------------------------------------------------
    // Panel state
    // ------------------------------------------------------------------
    logic [7:0]  hour_hist_reg,  hour_hist_next;
    logic [7:0]  menu_hist_reg,  menu_hist_next;
    logic [7:0]  min_hist_reg,   min_hist_next;
    logic        menu_mode_reg,  menu_mode_next;
    logic [15:0] inact_reg,      inact_next;
    logic [9:0]  millis_reg,     millis_next;
    logic [8:0]  blink_cnt_reg,  blink_cnt_next;
    logic [1:0]  scan_pos_reg,   scan_pos_next;

    // result fields computed this pass
    logic [3:0]  anode_next;
    logic [9:0]  cathode_next;
    logic        colon_next;
    logic        hstep_next;
    logic        mstep_next;

    // working values
    logic        toggle;
    logic        mode_tog;
    logic [15:0] inact_tog;
    logic [9:0]  millis_base;
    logic [8:0]  blink_inc;
    logic [3:0]  digit_val;
    logic        lit;

    always_comb
    begin
        hour_hist_next = hour_hist_reg;
        menu_hist_next = menu_hist_reg;
        min_hist_next  = min_hist_reg;
        menu_mode_next = menu_mode_reg;
        inact_next     = inact_reg;
        millis_next    = millis_reg;
        blink_cnt_next = blink_cnt_reg;
        scan_pos_next  = scan_pos_reg;

        anode_next   = 4'd0;
        cathode_next = 10'd0;
        colon_next   = 1'b0;
        hstep_next   = 1'b0;
        mstep_next   = 1'b0;

        // button path
        hour_hist_next = {hour_hist_reg[6:0], s1_reg.hour_level};
        menu_hist_next = {menu_hist_reg[6:0], s1_reg.menu_level};
        min_hist_next  = {min_hist_reg[6:0],  s1_reg.minute_level};
        toggle         = (menu_hist_next == PRESS_PATTERN);
        mode_tog       = menu_mode_reg ^ toggle;
        inact_tog      = toggle ? cfg_reg.inactivity_ticks : inact_reg;
        millis_base    = (millis_reg > cfg_reg.second_wrap) ? 10'd0 : millis_reg;

        // scan path
        case (scan_pos_reg)
            2'd0:    digit_val = s1_reg.digit_zero;
            2'd1:    digit_val = s1_reg.digit_one;
            2'd2:    digit_val = s1_reg.digit_two;
            default: digit_val = s1_reg.digit_three;
        endcase
        blink_inc = blink_cnt_reg + 9'd1;

        // leading-zero blanking applies to the tens-of-hours digit only
        if (scan_pos_reg == 2'd0)
            lit = (s1_reg.digit_zero < DIGIT_LIMIT)
                  && ((s1_reg.digit_zero != 4'd0) || (s1_reg.digit_one == 4'd0));
        else
            lit = (digit_val < DIGIT_LIMIT);

        case (s1_reg.kind)
            REQ_BUTTON:
            begin
                scan_pos_next = scan_pos_reg;
                if (mode_tog)
                begin
                    hstep_next = (hour_hist_next == PRESS_PATTERN);
                    mstep_next = (min_hist_next == PRESS_PATTERN);
                    if (inact_tog != 16'd0)
                    begin
                        inact_next     = inact_tog - 16'd1;
                        menu_mode_next = 1'b1;
                    end
                    else
                    begin
                        inact_next     = inact_tog;
                        menu_mode_next = 1'b0;
                    end
                end
                else
                begin
                    inact_next     = inact_tog;
                    menu_mode_next = 1'b0;
                    millis_next    = millis_base + 10'd1;
                end
            end
            default:
            begin
                // scan tick leaves the button state alone
                hour_hist_next = hour_hist_reg;
                menu_hist_next = menu_hist_reg;
                min_hist_next  = min_hist_reg;

                blink_cnt_next = (blink_inc > cfg_reg.blink_period) ? 9'd0 : blink_inc;
                // dark phase: anode off, cathode still driven
                if (s1_reg.blink_mask[{1'b0, scan_pos_reg}]
                    && (blink_cnt_next <= cfg_reg.blink_dark))
                    lit = 1'b0;

                anode_next   = lit ? (4'b0001 << scan_pos_reg) : 4'd0;
                cathode_next = (digit_val < DIGIT_LIMIT) ? (10'b1 << digit_val) : 10'd0;
                colon_next   = s1_reg.blink_mask[7] ? (millis_reg < cfg_reg.colon_on_limit)
                                                    : 1'b1;
                scan_pos_next = scan_pos_reg + 2'd1;
            end
        endcase
    end

    logic state_load;
    assign state_load = s1_valid_reg && out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_hist_reg <= 8'd0;
            menu_hist_reg <= 8'd0;
            min_hist_reg  <= 8'd0;
            menu_mode_reg <= 1'b0;
            inact_reg     <= 16'd0;
            millis_reg    <= 10'd0;
            blink_cnt_reg <= 9'd0;
            scan_pos_reg  <= 2'd0;
        end
        else if (state_load)
        begin
            hour_hist_reg <= hour_hist_next;
            menu_hist_reg <= menu_hist_next;
            min_hist_reg  <= min_hist_next;
            menu_mode_reg <= menu_mode_next;
            inact_reg     <= inact_next;
            millis_reg    <= millis_next;
            blink_cnt_reg <= blink_cnt_next;
            scan_pos_reg  <= scan_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        rsp_valid_reg;
    logic [3:0]  anode_reg;
    logic [9:0]  cathode_reg;
    logic        colon_reg;
    logic        menu_active_reg;
    logic        hstep_reg;
    logic        mstep_reg;
    logic [15:0] inact_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_load)
        begin
            anode_reg       <= anode_next;
            cathode_reg     <= cathode_next;
            colon_reg       <= colon_next;
            menu_active_reg <= menu_mode_next;
            hstep_reg       <= hstep_next;
            mstep_reg       <= mstep_next;
            inact_left_reg  <= inact_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign anode_lines     = anode_reg;
    assign cathode_lines   = cathode_reg;
    assign colon_lamp      = colon_reg;
    assign menu_active     = menu_active_reg;
    assign hour_step       = hstep_reg;
    assign minute_step     = mstep_reg;
    assign inactivity_left = inact_left_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_anode_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0(anode_lines))
        else $error("anode lines not one-hot");

    a_lit_has_cathode: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (anode_lines != 4'd0)) |-> $onehot(cathode_lines))
        else $error("lit digit without a cathode");

    // a step on the tick that runs the timer out leaves the menu with the timer at zero
    a_step_in_menu: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (hour_step || minute_step))
        |-> (menu_active || (inactivity_left == 16'd0)))
        else $error("step pulse outside menu mode");

    a_scan_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (anode_lines != 4'd0)) |-> (!hour_step && !minute_step))
        else $error("step pulse on a scan result");

    a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_load && (s1_reg.kind == REQ_SCAN))
        |=> (scan_pos_reg == $past(scan_pos_reg) + 2'd1))
        else $error("scan position did not advance");

endmodule

// ===== bench/tb_nixie_panel_scan_and_menu_ctrl_top.sv =====
// Self-checking bench for the tube panel scan and menu controller: button and scan
// requests in, panel results checked field by field against an in-bench predictor.
// Depends on npsmc_pkg and nixie_panel_scan_and_menu_ctrl_top.
`timescale 1ns / 1ps

module tb_nixie_panel_scan_and_menu_ctrl_top;

    import npsmc_pkg::*;

    localparam int COLON_BLINK_BIT = 7;     // blink_mask bit that blinks the colon lamp
    localparam int DRAIN_CYCLES    = 10;    // tail after the last result
    localparam int RUN_LIMIT_NS    = 1000000;

    // One expected panel result
    typedef struct packed {
        logic [3:0]  anode;
        logic [9:0]  cathode;
        logic        colon;
        logic        menu;
        logic        hour_step;
        logic        minute_step;
        logic [15:0] inactivity;
    } panel_out_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   req_valid           = 1'b0;
    logic                   req_stall;
    logic                   req_type            = 1'b0;
    logic                   hour_button_level   = 1'b1;
    logic                   menu_button_level   = 1'b1;
    logic                   minute_button_level = 1'b1;
    logic [3:0]             digit_zero          = '0;
    logic [3:0]             digit_one           = '0;
    logic [3:0]             digit_two           = '0;
    logic [3:0]             digit_three         = '0;
    logic [7:0]             blink_mask          = '0;

    logic                   rsp_valid;
    logic                   rsp_stall           = 1'b0;
    logic [3:0]             anode_lines;
    logic [9:0]             cathode_lines;
    logic                   colon_lamp;
    logic                   menu_active;
    logic                   hour_step;
    logic                   minute_step;
    logic [15:0]            inactivity_left;

    logic                   cfg_valid           = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index           = '0;
    logic [CFG_DATA_W-1:0]  cfg_data            = '0;

    always #5 clk = ~clk;

    nixie_panel_scan_and_menu_ctrl_top u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_stall           (req_stall),
        .req_type            (req_type),
        .hour_button_level   (hour_button_level),
        .menu_button_level   (menu_button_level),
        .minute_button_level (minute_button_level),
        .digit_zero          (digit_zero),
        .digit_one           (digit_one),
        .digit_two           (digit_two),
        .digit_three         (digit_three),
        .blink_mask          (blink_mask),
        .rsp_valid           (rsp_valid),
        .rsp_stall           (rsp_stall),
        .anode_lines         (anode_lines),
        .cathode_lines       (cathode_lines),
        .colon_lamp          (colon_lamp),
        .menu_active         (menu_active),
        .hour_step           (hour_step),
        .minute_step         (minute_step),
        .inactivity_left     (inactivity_left),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state: request queue, expected panel results, idle knobs
    // ------------------------------------------------------------------
    req_t       pending_req[$];
    panel_out_t expected_panel[$];
    int         fail_count = 0;
    int         idle_pct   = 9;     // sender gap chance, percent
    int         stall_pct  = 9;     // receiver stall chance, percent

    // Button level generators for well-formed press sequences
    logic lvl_hour = 1'b1, lvl_menu = 1'b1, lvl_min = 1'b1;
    int   run_hour = 0, run_menu = 0, run_min = 0;

    // ------------------------------------------------------------------
    // Panel predictor: own copy of config and state, reset values as in
    // the package.
    // ------------------------------------------------------------------
    cfg_t panel_cfg = '{inactivity_ticks: RST_INACTIVITY,
                        blink_period:     RST_BLINK_PERIOD,
                        blink_dark:       RST_BLINK_DARK,
                        colon_on_limit:   RST_COLON_ON_LIMIT,
                        second_wrap:      RST_SECOND_WRAP};

    logic [7:0]  hour_hist   = '0;
    logic [7:0]  menu_hist   = '0;
    logic [7:0]  minute_hist = '0;
    logic        menu_on     = 1'b0;
    logic [15:0] idle_left   = '0;
    logic [9:0]  ms_count    = '0;
    logic [8:0]  blink_cnt   = '0;
    logic [1:0]  scan_pos    = '0;

    function automatic panel_out_t predict_panel(input req_t r);
        panel_out_t o;
        logic [3:0] digit [4];
        logic [3:0] val;
        logic       lit;
        o = '0;
        if (r.kind == REQ_BUTTON) begin
            hour_hist   = {hour_hist[6:0], r.hour_level};
            menu_hist   = {menu_hist[6:0], r.menu_level};
            minute_hist = {minute_hist[6:0], r.minute_level};
            // a menu toggle reloads the timer, also on the way out
            if (menu_hist == PRESS_PATTERN) begin
                menu_on   = ~menu_on;
                idle_left = panel_cfg.inactivity_ticks;
            end
            if (menu_on) begin
                o.hour_step   = (hour_hist == PRESS_PATTERN);
                o.minute_step = (minute_hist == PRESS_PATTERN);
                if (idle_left != 16'd0)
                    idle_left = idle_left - 16'd1;
                else
                    menu_on = 1'b0;
            end
            else begin
                if (ms_count > panel_cfg.second_wrap)
                    ms_count = '0;
                ms_count = ms_count + 10'd1;    // wraps in 10 bits
            end
        end
        else begin
            digit[0] = r.digit_zero;
            digit[1] = r.digit_one;
            digit[2] = r.digit_two;
            digit[3] = r.digit_three;
            val = digit[scan_pos];
            // a zero tens of hours is blanked only when the units are nonzero
            if (scan_pos == 2'd0)
                lit = (r.digit_zero < DIGIT_LIMIT) &&
                      (r.digit_zero != 4'd0 || r.digit_one == 4'd0);
            else
                lit = (val < DIGIT_LIMIT);
            blink_cnt = blink_cnt + 9'd1;       // wraps in 9 bits
            if (blink_cnt > panel_cfg.blink_period)
                blink_cnt = '0;
            // dark phase kills the anode only, cathode stays driven
            if (r.blink_mask[{1'b0, scan_pos}] && blink_cnt <= panel_cfg.blink_dark)
                lit = 1'b0;
            o.anode   = lit ? (4'b0001 << scan_pos) : 4'b0000;
            o.cathode = (val < DIGIT_LIMIT) ? (10'b1 << val) : 10'b0;
            o.colon   = r.blink_mask[COLON_BLINK_BIT] ?
                        (ms_count < panel_cfg.colon_on_limit) : 1'b1;
            scan_pos  = scan_pos + 2'd1;
        end
        o.menu       = menu_on;
        o.inactivity = idle_left;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Inputs sampled here are the values before the edge,
    // so an accepted request is the one that was on the pins. A held
    // request keeps its payload until the DUT takes it.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : req_driver
        req_t taken;
        req_t nxt;
        if (rst_n) begin
            if (req_valid && !req_stall) begin
                taken.kind         = req_type_t'(req_type);
                taken.hour_level   = hour_button_level;
                taken.menu_level   = menu_button_level;
                taken.minute_level = minute_button_level;
                taken.digit_zero   = digit_zero;
                taken.digit_one    = digit_one;
                taken.digit_two    = digit_two;
                taken.digit_three  = digit_three;
                taken.blink_mask   = blink_mask;
                expected_panel.push_back(predict_panel(taken));
            end
            if (!req_valid || !req_stall) begin
                if (pending_req.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = pending_req.pop_front();
                    req_valid           <= 1'b1;
                    req_type            <= nxt.kind;
                    hour_button_level   <= nxt.hour_level;
                    menu_button_level   <= nxt.menu_level;
                    minute_button_level <= nxt.minute_level;
                    digit_zero          <= nxt.digit_zero;
                    digit_one           <= nxt.digit_one;
                    digit_two           <= nxt.digit_two;
                    digit_three         <= nxt.digit_three;
                    blink_mask          <= nxt.blink_mask;
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: in-order compare against the oldest expectation,
    // random back-pressure on the result channel.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : rsp_monitor
        panel_out_t want;
        if (rst_n) begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_panel.size() == 0) begin
                    $display("%0t: result with none expected, anode %0d cathode %0d menu %0d",
                             $time, anode_lines, cathode_lines, menu_active);
                    fail_count++;
                end
                else begin
                    want = expected_panel.pop_front();
                    check_field("anode_lines", 16'(want.anode), 16'(anode_lines));
                    check_field("cathode_lines", 16'(want.cathode), 16'(cathode_lines));
                    check_field("colon_lamp", 16'(want.colon), 16'(colon_lamp));
                    check_field("menu_active", 16'(want.menu), 16'(menu_active));
                    check_field("hour_step", 16'(want.hour_step), 16'(hour_step));
                    check_field("minute_step", 16'(want.minute_step), 16'(minute_step));
                    check_field("inactivity_left", want.inactivity, inactivity_left);
                end
            end
            rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_button(input logic h, input logic m, input logic mn);
        req_t r;
        r.kind         = REQ_BUTTON;
        r.hour_level   = h;
        r.menu_level   = m;
        r.minute_level = mn;
        // display fields are don't-care on a button tick; keep them moving
        r.digit_zero   = 4'($urandom_range(0, 15));
        r.digit_one    = 4'($urandom_range(0, 15));
        r.digit_two    = 4'($urandom_range(0, 15));
        r.digit_three  = 4'($urandom_range(0, 15));
        r.blink_mask   = 8'($urandom_range(0, 255));
        pending_req.push_back(r);
    endtask

    task automatic queue_scan(input logic [3:0] d0, input logic [3:0] d1,
                              input logic [3:0] d2, input logic [3:0] d3,
                              input logic [7:0] mask);
        req_t r;
        r.kind         = REQ_SCAN;
        r.hour_level   = 1'($urandom_range(0, 1));
        r.menu_level   = 1'($urandom_range(0, 1));
        r.minute_level = 1'($urandom_range(0, 1));
        r.digit_zero   = d0;
        r.digit_one    = d1;
        r.digit_two    = d2;
        r.digit_three  = d3;
        r.blink_mask   = mask;
        pending_req.push_back(r);
    endtask

    // Mostly decimal digits, some blanks
    function automatic logic [3:0] rand_digit();
        if ($urandom_range(0, 9) < 8)
            return 4'($urandom_range(0, 9));
        return 4'($urandom_range(10, 15));
    endfunction

    // Run-length level generator: released runs up to rel_max, pressed 1..8.
    // Runs of four or more each way make the press pattern; short ones break it.
    task automatic step_level(inout logic lvl, inout int run, input int rel_max);
        if (run == 0) begin
            lvl = ~lvl;
            run = lvl ? $urandom_range(1, rel_max) : $urandom_range(1, 8);
        end
        run--;
    endtask

    task automatic queue_random(input int n, input int scan_pct, input bit menu_ok);
        @(negedge clk);
        repeat (n) begin
            if ($urandom_range(0, 99) < scan_pct) begin
                queue_scan(rand_digit(), rand_digit(), rand_digit(), rand_digit(),
                           8'($urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 9) == 0) begin
                // noise tick
                queue_button(1'($urandom_range(0, 1)),
                             menu_ok ? 1'($urandom_range(0, 1)) : 1'b1,
                             1'($urandom_range(0, 1)));
            end
            else begin
                step_level(lvl_hour, run_hour, 10);
                step_level(lvl_menu, run_menu, 40);
                step_level(lvl_min, run_min, 10);
                queue_button(lvl_hour, menu_ok ? lvl_menu : 1'b1, lvl_min);
            end
        end
    endtask

    // Idle means: nothing queued, nothing on the request pins, nothing owed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_req.size() != 0 || req_valid || expected_panel.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_INACTIVITY_TICKS: panel_cfg.inactivity_ticks = val;
            CFG_BLINK_PERIOD:     panel_cfg.blink_period     = val[8:0];
            CFG_BLINK_DARK:       panel_cfg.blink_dark       = val[8:0];
            CFG_COLON_ON_LIMIT:   panel_cfg.colon_on_limit   = val[9:0];
            CFG_SECOND_WRAP:      panel_cfg.second_wrap      = val[9:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Drain, load all five registers, then queue one random phase
    task automatic run_phase(input logic [15:0] inact, input logic [8:0] period,
                             input logic [8:0] dark, input logic [9:0] colon,
                             input logic [9:0] wrap, input int n, input int scan_pct,
                             input bit menu_ok, input int idle);
        wait_drained();
        write_reg(CFG_INACTIVITY_TICKS, inact);
        write_reg(CFG_BLINK_PERIOD, 16'(period));
        write_reg(CFG_BLINK_DARK, 16'(dark));
        write_reg(CFG_COLON_ON_LIMIT, 16'(colon));
        write_reg(CFG_SECOND_WRAP, 16'(wrap));
        idle_pct  = idle;
        stall_pct = idle;
        queue_random(n, scan_pct, menu_ok);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed scans at reset config. Scan position steps 0,1,2,3,0,...
        queue_scan(4'd0, 4'd0, 4'd9, 4'd9, 8'h00);      // zero tens with zero units: lit
        queue_scan(4'd0, 4'd5, 4'd9, 4'd9, 8'h00);
        queue_scan(4'd1, 4'd2, 4'd10, 4'd3, 8'h00);     // blank code on digit two
        queue_scan(4'd1, 4'd2, 4'd3, 4'd15, 8'h80);     // blank, colon blinking
        queue_scan(4'd0, 4'd5, 4'd3, 4'd4, 8'h00);      // leading zero blanked
        queue_scan(4'd2, 4'd9, 4'd3, 4'd4, 8'h0F);      // dark phase, cathode still on
        queue_scan(4'd2, 4'd3, 4'd0, 4'd4, 8'hFF);
        queue_scan(4'd2, 4'd3, 4'd5, 4'd9, 8'h7F);
        queue_scan(4'd15, 4'd0, 4'd5, 4'd9, 8'h00);     // blank tens of hours
        queue_scan(4'd9, 4'd9, 4'd15, 4'd15, 8'h01);

        // Menu press: four released ticks then four pressed -> enter menu
        repeat (4) queue_button(1'b1, 1'b1, 1'b1);
        repeat (4) queue_button(1'b1, 1'b0, 1'b1);
        // Hour and minute press inside the menu
        repeat (4) queue_button(1'b0, 1'b0, 1'b0);
        queue_scan(4'd1, 4'd2, 4'd3, 4'd4, 8'h80);

        queue_random(60, 40, 1'b1);

        // Low extremes, including a zero timer reload
        run_phase(16'd0, 9'd1, 9'd0, 10'd0, 10'd1, 80, 40, 1'b1, 9);
        // High extremes; menu held off so the millisecond count wraps its width
        run_phase(16'd65535, 9'd511, 9'd511, 10'd1023, 10'd1023, 1120, 2, 1'b0, 9);
        // Blink count keeps climbing to its width; no idling on either side
        run_phase(16'd3, 9'd511, 9'd200, 10'd600, 10'd700, 560, 95, 1'b1, 0);
        repeat (3)
            run_phase(16'($urandom_range(1, 40)), 9'($urandom_range(1, 511)),
                      9'($urandom_range(0, 511)), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(1, 1023)), 50, 35, 1'b1, 9);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hang guard
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
